### design/ftr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftr_pkg: shared constants for the fan tachometer speed block
// Widths of the tick counter and of the numerator, and the numerator reset.
// ----------------------------------------------------------------------------
package ftr_pkg;

    // Tick counter width (free-running microsecond time base)
    localparam int TIME_BITS = 32;

    // Numerator and speed width
    localparam int NUM_W = 24;

    // Compare window of the serial divider: one bit above the numerator
    localparam int CMP_W = NUM_W + 1;

    // Iteration counter width of the serial divider
    localparam int CNT_W = $clog2(NUM_W);

    // Default numerator: 60 * 1000000 ticks per minute over 4 pulses per rev
    localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(60 * 1000000 / 4);

endpackage

### design/ftr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftr_div: bit-serial restoring divider
// Shifts the numerator through a remainder register one bit per cycle and
// builds the truncated quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module ftr_div
    import ftr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_W-1:0]     dividend,
    input  logic [TIME_BITS-1:0] divisor,
    output logic                 done,
    output logic [NUM_W-1:0]     quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [NUM_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic                 big_reg, big_next;
    logic [CMP_W-1:0]     dlow_reg, dlow_next;

    logic [CMP_W-1:0]     trial;
    logic                 fits;
    logic [CMP_W-1:0]     diff;

    // Bring down the next numerator bit and try the subtract
    always_comb
    begin
        trial = {1'b0, rem_reg} << 1;
        trial[0] = quo_reg[NUM_W-1];
        fits  = !big_reg && (trial >= dlow_reg);
        diff  = trial - dlow_reg;
    end

    // Sequence the iterations
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        big_next  = big_reg;
        dlow_next = dlow_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            big_next  = (divisor >> CMP_W) != '0;
            dlow_next = CMP_W'(divisor);
        end
        else if (busy_reg)
        begin
            // Remainder never exceeds the numerator, so it fits NUM_W bits
            rem_next = fits ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold datapath shift registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        big_reg  <= big_next;
        dlow_reg <= dlow_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### design/fan_tach_pulse_rpm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_tach_pulse_rpm: fan speed from the high width of the tach pulse
// Times the high phase of the sampled tach level and divides a configured
// numerator by that width to give the fan speed in rpm.
// ----------------------------------------------------------------------------
// Each input item is one microsecond tick carrying the sampled tach level in
// bit 0 of s_axis_tdata; each tick yields exactly one output item carrying
// the current rpm (tdata) and a fresh-measurement flag (tuser). A falling
// level that ends a valid high phase starts the bit-serial divider, which
// produces one quotient bit per cycle; the next item is not taken until
// that quotient has been loaded into the output register. The output
// register holds a result until it is taken; the next item is accepted no
// earlier than the cycle in which the waiting result leaves. rate_numerator
// is written through cfg_we / cfg_wdata and should only change while the
// block is idle.
// ----------------------------------------------------------------------------
module fan_tach_pulse_rpm
    import ftr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // Configuration: rate_numerator
    input  logic             cfg_we,
    input  logic [NUM_W-1:0] cfg_wdata,
    // Input items
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [0] tach_level, [7:1] zero
    // Result items
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [NUM_W-1:0] m_axis_tdata,   // [23:0] rpm
    output logic [0:0]       m_axis_tuser    // [0] new_measurement
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [NUM_W-1:0]     numer_reg, numer_next;
    logic [TIME_BITS-1:0] tick_reg, tick_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic                 timing_reg, timing_next;
    logic [NUM_W-1:0]     speed_reg, speed_next;
    logic                 ovalid_reg, ovalid_next;
    logic [NUM_W-1:0]     orpm_reg, orpm_next;
    logic                 onew_reg, onew_next;

    logic                 out_free;
    logic                 in_acc;
    logic                 level;
    logic                 div_start;
    logic [TIME_BITS-1:0] width;
    logic                 div_done;
    logic [NUM_W-1:0]     div_quo;

    assign out_free      = !ovalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign level         = s_axis_tdata[0];
    assign width         = tick_reg - start_reg;

    // Serial divider
    ftr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (numer_reg),
        .divisor  (width),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Advance tick state, run the divider and load the output register
    always_comb
    begin
        state_next  = state_reg;
        numer_next  = cfg_we ? cfg_wdata : numer_reg;
        tick_next   = tick_reg;
        start_next  = start_reg;
        timing_next = timing_reg;
        speed_next  = speed_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        orpm_next   = orpm_reg;
        onew_next   = onew_reg;
        div_start   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    tick_next = tick_reg + 1'b1;
                    if (!level && timing_reg && (tick_reg > start_reg))
                    begin
                        // Valid high phase ended: divide
                        timing_next = 1'b0;
                        div_start   = 1'b1;
                        state_next  = ST_DIV;
                    end
                    else
                    begin
                        if (!level && timing_reg)
                        begin
                            // Counter wrapped: drop the measurement
                            timing_next = 1'b0;
                        end
                        else if (level && !timing_reg)
                        begin
                            start_next  = tick_reg;
                            timing_next = 1'b1;
                        end
                        ovalid_next = 1'b1;
                        orpm_next   = speed_reg;
                        onew_next   = 1'b0;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    speed_next = div_quo;
                    if (out_free)
                    begin
                        ovalid_next = 1'b1;
                        orpm_next   = div_quo;
                        onew_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    orpm_next   = speed_reg;
                    onew_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control and measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            numer_reg  <= NUM_RESET;
            tick_reg   <= '0;
            start_reg  <= '0;
            timing_reg <= 1'b0;
            speed_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            numer_reg  <= numer_next;
            tick_reg   <= tick_next;
            start_reg  <= start_next;
            timing_reg <= timing_next;
            speed_reg  <= speed_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Hold output payload
    always_ff @(posedge clk)
    begin
        orpm_reg <= orpm_next;
        onew_reg <= onew_next;
    end

    assign m_axis_tvalid   = ovalid_reg;
    assign m_axis_tdata    = orpm_reg;
    assign m_axis_tuser[0] = onew_reg;

endmodule

### tb/tb_fan_tach_pulse_rpm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fan_tach_pulse_rpm: self-checking bench for the tach pulse speed block
// Feeds sampled tach levels, one per tick, and checks every result item
// (rpm and fresh-measurement flag) against a tick-accurate speed predictor.
// A short directed run covers the extreme numerators and pulse widths.
// Random phases then follow, each under its own numerator, made mostly of
// clean pulses and partly of level noise. Both sides of the stream stall
// at random, except in one phase that runs without gaps.
// ----------------------------------------------------------------------------
module tb_fan_tach_pulse_rpm;
    import ftr_pkg::*;

    localparam logic LEVEL_LOW   = 1'b0;
    localparam logic LEVEL_HIGH  = 1'b1;
    localparam int   GAP_PCT     = 8;
    localparam int   SETTLE_CYC  = 30;
    localparam int   STALL_LIMIT = 2000;
    localparam int   PHASE_TICKS = 230;
    localparam int   NUM_PHASES  = 6;
    localparam int   MAX_REPORTS = 20;

    typedef struct packed {
        logic [NUM_W-1:0] rpm;
        logic             fresh;
    } speed_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [NUM_W-1:0] cfg_wdata = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = '0;   // [0] tach_level, [7:1] zero
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [NUM_W-1:0] m_axis_tdata;        // [23:0] rpm
    logic [0:0]       m_axis_tuser;        // [0] new_measurement

    // Predictor state: tick time base, timed high phase, last speed
    logic [NUM_W-1:0]     rate_num = NUM_RESET;
    logic [TIME_BITS-1:0] tick_now = '0;
    logic [TIME_BITS-1:0] high_start = '0;
    logic                 timing = 1'b0;
    logic [NUM_W-1:0]     rpm_value = '0;

    logic          pending_ticks[$];
    speed_result_t speed_expected[$];
    logic          steady = 1'b0;
    int            ticks_sent = 0;
    int            updates_checked = 0;
    int            errors = 0;
    int            stall_cycles = 0;
    int            settings_used = 1;

    fan_tach_pulse_rpm dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // Advance the predictor by one tick and return the expected result item
    function automatic speed_result_t advance_tick(input logic level);
        speed_result_t        r;
        logic [TIME_BITS-1:0] width_ticks;
        logic [TIME_BITS-1:0] quotient;
        r.fresh = 1'b0;
        if (!level && timing)
        begin
            timing = 1'b0;
            // a wrapped counter ends timing but keeps the old speed
            if (tick_now > high_start)
            begin
                width_ticks = tick_now - high_start;
                quotient = TIME_BITS'(rate_num) / width_ticks;
                rpm_value = quotient[NUM_W-1:0];
                r.fresh = 1'b1;
            end
        end
        else if (level && !timing)
        begin
            high_start = tick_now;
            timing = 1'b1;
        end
        tick_now = tick_now + 1'b1;
        r.rpm = rpm_value;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    // Queue one high phase followed by a low phase
    task automatic push_pulse(input int high_len, input int low_len);
        repeat (high_len) pending_ticks.push_back(LEVEL_HIGH);
        repeat (low_len) pending_ticks.push_back(LEVEL_LOW);
    endtask

    // Hold until every tick is sent and every result item has come back
    task automatic wait_idle();
        while (pending_ticks.size() != 0 || s_axis_tvalid || speed_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_numerator(input logic [NUM_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        rate_num = value;
    endtask

    // Driver: present queued ticks, predict on each accepted item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                speed_expected.push_back(advance_tick(s_axis_tdata[0]));
                ticks_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= GAP_PCT))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {7'b0, pending_ticks.pop_front()};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, check each accepted result item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= steady || ($urandom_range(99) >= GAP_PCT);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (speed_expected.size() == 0)
                begin
                    report_mismatch($sformatf("result with none expected, rpm %0d flag %0b",
                                              m_axis_tdata, m_axis_tuser[0]));
                end
                else
                begin
                    speed_result_t want;
                    want = speed_expected.pop_front();
                    if (m_axis_tdata !== want.rpm)
                        report_mismatch($sformatf("rpm got %0d want %0d",
                                                  m_axis_tdata, want.rpm));
                    if (m_axis_tuser[0] !== want.fresh)
                        report_mismatch($sformatf("new_measurement got %0b want %0b",
                                                  m_axis_tuser[0], want.fresh));
                    if (want.fresh)
                        updates_checked++;
                end
            end
        end
    end

    // Watchdog: end the run when no item moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no item moved for %0d cycles", $realtime, STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Stimulus: directed corner cases, then random phases
    initial
    begin
        logic [NUM_W-1:0] phase_num;
        int               roll;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default numerator: idle low, widths of two, one and three ticks
        pending_ticks = '{LEVEL_LOW, LEVEL_HIGH, LEVEL_HIGH, LEVEL_LOW, LEVEL_LOW};
        push_pulse(1, 1);
        push_pulse(3, 1);
        wait_idle();

        // full-scale numerator over one tick gives the largest quotient
        write_numerator({NUM_W{1'b1}});
        push_pulse(1, 1);
        wait_idle();

        // zero numerator still counts as a fresh measurement
        write_numerator('0);
        push_pulse(1, 1);
        wait_idle();

        // smallest numerator: quotient of one, then truncated to zero
        write_numerator(NUM_W'(1));
        push_pulse(1, 1);
        push_pulse(2, 1);
        wait_idle();
        settings_used += 3;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: phase_num = NUM_RESET;
                1: phase_num = {NUM_W{1'b1}};
                2: phase_num = NUM_W'(1);
                4: phase_num = NUM_W'($urandom_range(1000, 1));
                default: phase_num = NUM_W'($urandom_range(24'hFFFFFF, 1));
            endcase
            write_numerator(phase_num);
            settings_used++;
            steady = (p == 3);
            while (pending_ticks.size() < PHASE_TICKS)
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    push_pulse($urandom_range(40, 1), $urandom_range(30, 1));
                else if (roll < 80)
                    push_pulse($urandom_range(400, 41), $urandom_range(20, 1));
                else
                    repeat ($urandom_range(8, 1))
                        pending_ticks.push_back(1'($urandom_range(1, 0)));
            end
            wait_idle();
        end
        steady = 1'b0;

        repeat (SETTLE_CYC) @(posedge clk);
        $display("Drove %0d tach ticks over %0d numerator settings;", ticks_sent, settings_used);
        $display("checked %0d speed updates, %0d mismatches.", updates_checked, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
design/ftr_pkg.sv
design/ftr_div.sv
design/fan_tach_pulse_rpm.sv
tb/tb_fan_tach_pulse_rpm.sv
